>>> rtl/aclf_pkg.sv
`default_nettype none

package aclf_pkg;

  // Default number of angular positions around one turn.
  localparam int POSITIONS_DEF = 720;

  // LED word layout.
  localparam int LED_W    = 4;
  localparam int LED_MARK = 0;
  localparam int LED_HOUR = 1;
  localparam int LED_MIN  = 2;
  localparam int LED_SEC  = 3;

  // Time constants.
  localparam int HALF_DAY_MINS  = 720;
  localparam int MINS_PER_HOUR  = 60;
  localparam int TICKS_PER_TURN = 60;
  localparam int MARKS          = 12;

  // Remainder width of a divide by HALF_DAY_MINS.
  localparam int REM_W = 10;

  // Function codes.
  localparam logic FUNC_TIME = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef logic [LED_W-1:0] led_word_t;

  typedef struct packed {
    logic       func;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [9:0] position;
  } in_item_t;

  typedef struct packed {
    logic hour_mark_on;
    logic hour_hand_on;
    logic minute_hand_on;
    logic second_arc_on;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/aclf_div.sv
`default_nettype none

// Divide by the half-day minute count with a reciprocal multiply: load,
// multiply, then form the remainder. done follows start through mul_r, sub_r and done_r.
module aclf_div #(
  parameter int DW = 20
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [DW-1:0]              dividend,
  output logic                            done,
  output logic [DW-1:0]                   quo,
  output logic [aclf_pkg::REM_W-1:0]      rem
);

  // A shift of DW + REM_W keeps the reciprocal error below 1/720 for every
  // dividend under 2**DW, so the quotient comes out exact.
  localparam int SH  = DW + aclf_pkg::REM_W;
  localparam int MW  = DW + 1;
  localparam int PRW = DW + MW;
  localparam logic [63:0] RECIP_L =
    ((64'd1 << SH) + 64'(aclf_pkg::HALF_DAY_MINS - 1)) / 64'(aclf_pkg::HALF_DAY_MINS);
  localparam logic [MW-1:0] RECIP = RECIP_L[MW-1:0];

  logic [DW-1:0]               dq_r;
  logic [DW-1:0]               quo_r;
  logic [aclf_pkg::REM_W-1:0]  rem_r;
  logic                        mul_r;
  logic                        sub_r;
  logic                        done_r;
  logic [PRW-1:0]              prod;
  logic [DW-1:0]               back;
  logic [DW-1:0]               diff;

  assign prod = PRW'(dq_r) * PRW'(RECIP);
  assign back = quo_r * DW'(aclf_pkg::HALF_DAY_MINS);
  assign diff = dq_r - back;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      sub_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= start;
      sub_r  <= mul_r;
      done_r <= sub_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r <= dividend;
    end
    if (mul_r) begin
      quo_r <= DW'(prod[PRW-1:SH]);
    end
    if (sub_r) begin
      rem_r <= diff[aclf_pkg::REM_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

>>> rtl/aclf_mem.sv
`default_nettype none

module aclf_mem #(
  parameter int DEPTH = 720,
  parameter int AW    = 10
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire aclf_pkg::led_word_t        wdata,
  input  wire logic [AW-1:0]              raddr,
  output aclf_pkg::led_word_t             rdata
);

  aclf_pkg::led_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/analog_clock_led_frame_unit.sv
`default_nettype none

// LED frame store for a spinning analog clock display.
// Input channel (in_valid / in_stall / in_data) takes one word per handshake.
//   func = read: the LED word at in_data.position is registered and out_valid
//   rises from the read-out step once the result register is free; the next
//   input word is taken only after that step returns to idle. Positions at or
//   beyond POSITIONS read as all dark.
//   func = time: the hands move and no result comes back. The hour position
// takes two passes through the shared divide-by-720 unit (reciprocal
// multiply, then remainder). Then every edit of the store is a
// read-modify-write sweep through the frame memory, in this order:
// old hour, old minute, the whole arc when seconds is 1,
//   new hour, new minute, then the arc span(s).
// Result channel (out_valid / out_stall / out_data) is a register: a result
// holds while out_stall is high. Time words still go through meanwhile; a
// further read waits in the read-out step with in_stall high until it drains.
// Reset: the store is rebuilt by a pass over all POSITIONS entries (hour marks, and
// all hands at the half-turn position); in_stall stays high until it ends.
module analog_clock_led_frame_unit #(
  parameter int POSITIONS = aclf_pkg::POSITIONS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire aclf_pkg::in_item_t    in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output aclf_pkg::out_item_t        out_data
);

  localparam int PW   = $clog2(POSITIONS);
  localparam int HALF = POSITIONS / 2;
  localparam int TICK = POSITIONS / aclf_pkg::TICKS_PER_TURN;
  localparam int STEP = POSITIONS / aclf_pkg::MARKS;
  localparam int SW   = $clog2(STEP);
  localparam int DW   = $clog2(aclf_pkg::HALF_DAY_MINS * POSITIONS);

  typedef enum logic [6:0] {
    ST_INIT  = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_RDOUT = 7'b0000100,
    ST_MOD   = 7'b0001000,
    ST_SCALE = 7'b0010000,
    ST_SWEEP = 7'b0100000,
    ST_DRAIN = 7'b1000000
  } state_t;

  // One sweep job per edit of the store.
  typedef enum logic [6:0] {
    JB_CLR_HOUR = 7'b0000001,
    JB_CLR_MIN  = 7'b0000010,
    JB_CLR_ARC  = 7'b0000100,
    JB_SET_HOUR = 7'b0001000,
    JB_SET_MIN  = 7'b0010000,
    JB_ARC_A    = 7'b0100000,
    JB_ARC_B    = 7'b1000000
  } job_t;

  function automatic logic [PW-1:0] tick_pos(input logic [5:0] v);
    logic [PW:0] t;
    t = (PW+1)'(TICK) * (PW+1)'(v) + (PW+1)'(HALF);
    if (t >= (PW+1)'(POSITIONS)) begin
      t = t - (PW+1)'(POSITIONS);
    end
    return t[PW-1:0];
  endfunction

  state_t               state_r, state_nxt;
  job_t                 job_r, job_nxt, job_after;

  logic [PW-1:0]        hour_at_r, min_at_r, sec_at_r;
  logic [PW-1:0]        new_hour_r, new_min_r, new_sec_r;
  logic                 clr_arc_r;
  logic [PW-1:0]        rd_addr_r;
  logic                 pend_r;
  logic [PW-1:0]        pend_addr_r;
  logic [PW-1:0]        init_addr_r;
  logic [PW-1:0]        init_cnt_r;
  logic [SW-1:0]        init_sub_r;
  logic [3:0]           init_k_r;
  logic                 div_go_r;
  logic [DW-1:0]        dividend_r;
  logic                 rd_ok_r;
  logic                 out_valid_r;
  aclf_pkg::out_item_t  out_data_r;

  logic                 accept;
  logic                 wrap;
  logic                 last_job;
  logic [PW-1:0]        job_lo, job_hi;
  logic                 div_done;
  logic [DW-1:0]        div_quo;
  logic [aclf_pkg::REM_W-1:0] div_rem;

  logic                 mem_we;
  logic [PW-1:0]        mem_waddr, mem_raddr;
  aclf_pkg::led_word_t  mem_wdata, mem_rdata, init_word, mod_word;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign wrap     = new_sec_r < sec_at_r;
  assign last_job = (job_r == JB_ARC_B) || ((job_r == JB_ARC_A) && !wrap);

  // Order of edits for one time update.
  always_comb begin
    unique case (job_r)
      JB_CLR_HOUR: job_after = JB_CLR_MIN;
      JB_CLR_MIN:  job_after = clr_arc_r ? JB_CLR_ARC : JB_SET_HOUR;
      JB_CLR_ARC:  job_after = JB_SET_HOUR;
      JB_SET_HOUR: job_after = JB_SET_MIN;
      JB_SET_MIN:  job_after = JB_ARC_A;
      JB_ARC_A:    job_after = JB_ARC_B;
      JB_ARC_B:    job_after = JB_ARC_B;
      default:     job_after = JB_CLR_HOUR;
    endcase
  end

  // Start of the job about to run, end of the job running.
  always_comb begin
    unique case (job_nxt)
      JB_CLR_HOUR: job_lo = hour_at_r;
      JB_CLR_MIN:  job_lo = min_at_r;
      JB_CLR_ARC:  job_lo = '0;
      JB_SET_HOUR: job_lo = new_hour_r;
      JB_SET_MIN:  job_lo = new_min_r;
      JB_ARC_A:    job_lo = wrap ? '0 : sec_at_r;
      JB_ARC_B:    job_lo = sec_at_r;
      default:     job_lo = '0;
    endcase
  end

  always_comb begin
    unique case (job_r)
      JB_CLR_HOUR: job_hi = hour_at_r;
      JB_CLR_MIN:  job_hi = min_at_r;
      JB_CLR_ARC:  job_hi = PW'(POSITIONS - 1);
      JB_SET_HOUR: job_hi = new_hour_r;
      JB_SET_MIN:  job_hi = new_min_r;
      JB_ARC_A:    job_hi = new_sec_r;
      JB_ARC_B:    job_hi = PW'(POSITIONS - 1);
      default:     job_hi = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    unique case (state_r)
      ST_INIT: begin
        if (init_cnt_r == PW'(POSITIONS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.func == aclf_pkg::FUNC_READ) ? ST_RDOUT : ST_MOD;
        end
      end
      ST_RDOUT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MOD: begin
        if (div_done) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (div_done) begin
          state_nxt = ST_SWEEP;
          job_nxt   = JB_CLR_HOUR;
        end
      end
      ST_SWEEP: begin
        if (rd_addr_r == job_hi) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (last_job) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SWEEP;
          job_nxt   = job_after;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      job_r       <= JB_CLR_HOUR;
      pend_r      <= 1'b0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      init_addr_r <= PW'(HALF);
      init_cnt_r  <= '0;
      init_sub_r  <= '0;
      init_k_r    <= '0;
      hour_at_r   <= PW'(HALF);
      min_at_r    <= PW'(HALF);
      sec_at_r    <= PW'(HALF);
    end else begin
      state_r  <= state_nxt;
      job_r    <= job_nxt;
      pend_r   <= (state_r == ST_SWEEP);
      div_go_r <= 1'b0;

      // Walk the store once after reset, starting at the half turn.
      if (state_r == ST_INIT) begin
        init_cnt_r  <= init_cnt_r + 1'b1;
        init_addr_r <= (init_addr_r == PW'(POSITIONS - 1)) ? '0 : init_addr_r + 1'b1;
        if (init_sub_r == SW'(STEP - 1)) begin
          init_sub_r <= '0;
          if (init_k_r != 4'(aclf_pkg::MARKS)) begin
            init_k_r <= init_k_r + 1'b1;
          end
        end else begin
          init_sub_r <= init_sub_r + 1'b1;
        end
      end

      if (accept && (in_data.func == aclf_pkg::FUNC_TIME)) begin
        div_go_r <= 1'b1;
      end
      if ((state_r == ST_MOD) && div_done) begin
        div_go_r <= 1'b1;
      end

      // Commit the new hands once every edit is in the store.
      if ((state_r == ST_DRAIN) && last_job) begin
        hour_at_r <= new_hour_r;
        min_at_r  <= new_min_r;
        sec_at_r  <= new_sec_r;
      end

      if ((state_r == ST_RDOUT) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    pend_addr_r <= rd_addr_r;
    if (accept) begin
      rd_ok_r    <= 32'(in_data.position) < POSITIONS;
      new_min_r  <= tick_pos(in_data.minutes);
      new_sec_r  <= tick_pos(in_data.seconds);
      clr_arc_r  <= (in_data.seconds == 6'd1);
      dividend_r <= DW'(in_data.hours) * DW'(aclf_pkg::MINS_PER_HOUR)
                    + DW'(in_data.minutes) + DW'(aclf_pkg::HALF_DAY_MINS / 2);
    end
    if ((state_r == ST_MOD) && div_done) begin
      // Scale minutes of the half day to positions.
      dividend_r <= DW'(div_rem) * DW'(POSITIONS);
    end
    if ((state_r == ST_SCALE) && div_done) begin
      new_hour_r <= div_quo[PW-1:0];
    end
    if (state_nxt == ST_SWEEP && state_r != ST_SWEEP) begin
      rd_addr_r <= job_lo;
    end else if (state_r == ST_SWEEP) begin
      rd_addr_r <= rd_addr_r + 1'b1;
    end else if (accept) begin
      // Hold the read position on the memory through the read-out step.
      rd_addr_r <= PW'(in_data.position);
    end
    if ((state_r == ST_RDOUT) && (!out_valid_r || !out_stall)) begin
      out_data_r.hour_mark_on   <= rd_ok_r & mem_rdata[aclf_pkg::LED_MARK];
      out_data_r.hour_hand_on   <= rd_ok_r & mem_rdata[aclf_pkg::LED_HOUR];
      out_data_r.minute_hand_on <= rd_ok_r & mem_rdata[aclf_pkg::LED_MIN];
      out_data_r.second_arc_on  <= rd_ok_r & mem_rdata[aclf_pkg::LED_SEC];
    end
  end

  // Reset contents: marks every STEP positions from the half turn, hands there.
  always_comb begin
    init_word = '0;
    init_word[aclf_pkg::LED_MARK] = (init_sub_r == '0) &&
                                    (init_k_r < 4'(aclf_pkg::MARKS));
    if (init_cnt_r == '0) begin
      init_word[aclf_pkg::LED_HOUR] = 1'b1;
      init_word[aclf_pkg::LED_MIN]  = 1'b1;
      init_word[aclf_pkg::LED_SEC]  = 1'b1;
    end
  end

  // Modify step of the read-modify-write sweep.
  always_comb begin
    mod_word = mem_rdata;
    unique case (job_r)
      JB_CLR_HOUR: mod_word[aclf_pkg::LED_HOUR] = 1'b0;
      JB_CLR_MIN:  mod_word[aclf_pkg::LED_MIN]  = 1'b0;
      JB_CLR_ARC:  mod_word[aclf_pkg::LED_SEC]  = 1'b0;
      JB_SET_HOUR: mod_word[aclf_pkg::LED_HOUR] = 1'b1;
      JB_SET_MIN:  mod_word[aclf_pkg::LED_MIN]  = 1'b1;
      JB_ARC_A:    mod_word[aclf_pkg::LED_SEC]  = 1'b1;
      JB_ARC_B:    mod_word[aclf_pkg::LED_SEC]  = 1'b1;
      default:     mod_word = mem_rdata;
    endcase
  end

  assign mem_we    = (state_r == ST_INIT) || pend_r;
  assign mem_waddr = (state_r == ST_INIT) ? init_addr_r : pend_addr_r;
  assign mem_wdata = (state_r == ST_INIT) ? init_word : mod_word;
  assign mem_raddr = (state_r == ST_IDLE) ? PW'(in_data.position) : rd_addr_r;

  aclf_div #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (dividend_r),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  aclf_mem #(
    .DEPTH (POSITIONS),
    .AW    (PW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // Every accepted word takes the block out of idle in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted back to back");

  // The store is never written while idle, so reads see settled data.
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("frame write while idle");

  // A result appears only out of the read-out step.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_RDOUT))
    else $error("result without a read");

  // Reset always starts the rebuild pass with input held off.
  a_reset_init: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open right after reset");
`endif

endmodule

`default_nettype wire
